// ===== rtl/lpdc_pkg.sv =====
package lpdc_pkg;

  // lever count and lever index width
  localparam int unsigned NumLevers = 4;
  localparam int unsigned LeverW    = 2;

  // register reset values
  localparam logic [15:0] ShortTicksRst = 16'd5;
  localparam logic [15:0] MidTicksRst   = 16'd200;
  localparam logic [15:0] LongTicksRst  = 16'd800;

  // configuration register indexes
  localparam logic [1:0] CfgShort = 2'd0;
  localparam logic [1:0] CfgMid   = 2'd1;
  localparam logic [1:0] CfgLong  = 2'd2;

  // event flag bits
  localparam logic [3:0] EvShort    = 4'h1;
  localparam logic [3:0] EvMid      = 4'h2;
  localparam logic [3:0] EvLong     = 4'h4;
  localparam logic [3:0] EvPop      = 4'h8;
  localparam logic [3:0] EvPressAll = EvShort | EvMid | EvLong;

  typedef enum logic [1:0] {
    REQ_SCAN,
    REQ_SET,
    REQ_CLEAR,
    REQ_TEST
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSHED,
    ST_POP,
    ST_TIMEOUT
  } lever_st_e;

  // per-lever state entry, all zero after reset
  typedef struct packed {
    logic [15:0] last;
    logic [15:0] kept;
    lever_st_e   status;
    logic [15:0] ticks;
    logic [3:0]  flags;
  } entry_t;

  // timing thresholds
  typedef struct packed {
    logic [15:0] short_ticks;
    logic [15:0] mid_ticks;
    logic [15:0] long_ticks;
  } thr_t;

endpackage

// ===== rtl/lpdc_update.sv =====
module lpdc_update (
  input  lpdc_pkg::entry_t cur_i,
  input  lpdc_pkg::thr_t   thr_i,
  input  logic [1:0]       req_type_i,
  input  logic [15:0]      lever_value_i,
  input  logic [3:0]       flag_mask_i,
  output lpdc_pkg::entry_t nxt_o
);

  lpdc_pkg::entry_t nxt;
  logic [15:0]      cnt;

  always_comb begin
    nxt = cur_i;
    cnt = '0;
    case (lpdc_pkg::req_e'(req_type_i))
      lpdc_pkg::REQ_SCAN: begin
        // reading changed: start a push or classify the release
        if (cur_i.last != lever_value_i) begin
          nxt.last = lever_value_i;
          nxt.kept = lever_value_i;
          if (lever_value_i != '0) begin
            nxt.status = lpdc_pkg::ST_PUSHED;
            nxt.ticks  = '0;
            nxt.flags  = nxt.flags & ~lpdc_pkg::EvPressAll;
          end else if (cur_i.ticks >= thr_i.short_ticks) begin
            nxt.status = lpdc_pkg::ST_POP;
            nxt.flags  = nxt.flags | lpdc_pkg::EvPop;
          end else begin
            nxt.status = lpdc_pkg::ST_IDLE;
          end
        end
        // pushed: saturating count, threshold flags, timeout
        if (nxt.status == lpdc_pkg::ST_PUSHED) begin
          cnt = (nxt.ticks != '1) ? nxt.ticks + 16'd1 : nxt.ticks;
          nxt.ticks = cnt;
          if (cnt == thr_i.long_ticks) begin
            nxt.flags = nxt.flags | lpdc_pkg::EvLong;
          end else if (cnt == thr_i.mid_ticks) begin
            nxt.flags = nxt.flags | lpdc_pkg::EvMid;
          end else if (cnt == thr_i.short_ticks) begin
            nxt.flags = nxt.flags | lpdc_pkg::EvShort;
          end
          if (cnt > thr_i.long_ticks) begin
            nxt.status = lpdc_pkg::ST_TIMEOUT;
          end
        end
      end
      lpdc_pkg::REQ_SET: begin
        nxt.flags = cur_i.flags | flag_mask_i;
      end
      lpdc_pkg::REQ_CLEAR: begin
        nxt.flags = cur_i.flags & ~flag_mask_i;
      end
      default: begin
      end
    endcase
  end

  assign nxt_o = nxt;

endmodule

// ===== rtl/lever_press_duration_classifier.sv =====
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid_i / in_stall_o | req_type_i lever_id_i lever_value_i flag_mask_i
// output   | out_valid_o / out_stall_i | held_value_o lever_state_o press_ticks_o
//          |                        | event_bits_o mask_all_set_o
// config   | cfg_we_i               | cfg_idx_i cfg_data_i
//
// one request per cycle sustained while the output is not stalled; a result is
// registered in steps (state memory read at acceptance, then update into the output register)
// the read-modify-write on the state memory sets the rate: a write of the
// previous request is forwarded, so requests to the same lever run back to back
// reset clears the thresholds to their defaults and marks every lever entry
// invalid; an invalid entry reads as all zero, so no clearing pass is needed
// a stalled output holds the update stage, and the input stalls only while both
// the update stage and the output register are full and the output is stalled
module lever_press_duration_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [1:0]  lever_id_i,
  input  logic [15:0] lever_value_i,
  input  logic [3:0]  flag_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] held_value_o,
  output logic [1:0]  lever_state_o,
  output logic [15:0] press_ticks_o,
  output logic [3:0]  event_bits_o,
  output logic        mask_all_set_o
);

  // configuration registers
  lpdc_pkg::thr_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.short_ticks <= lpdc_pkg::ShortTicksRst;
      thr_q.mid_ticks   <= lpdc_pkg::MidTicksRst;
      thr_q.long_ticks  <= lpdc_pkg::LongTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpdc_pkg::CfgShort: thr_q.short_ticks <= cfg_data_i;
        lpdc_pkg::CfgMid:   thr_q.mid_ticks   <= cfg_data_i;
        lpdc_pkg::CfgLong:  thr_q.long_ticks  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  logic                        s1_vld_q;
  logic                        out_vld_q;
  logic                        s1_adv;
  logic                        in_acc;
  logic                        in_range;
  logic                        wr_en;

  assign s1_adv     = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // update stage request registers
  logic [1:0]                  s1_req_q;
  logic [lpdc_pkg::LeverW-1:0] s1_lever_q;
  logic [15:0]                 s1_value_q;
  logic [3:0]                  s1_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q   <= req_type_i;
      s1_lever_q <= lever_id_i;
      s1_value_q <= lever_value_i;
      s1_mask_q  <= flag_mask_i;
    end
  end

  // state memory, read on acceptance, written when the update stage retires
  lpdc_pkg::entry_t mem_q [lpdc_pkg::NumLevers];
  lpdc_pkg::entry_t rd_entry_q;
  lpdc_pkg::entry_t upd_entry;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s1_lever_q] <= upd_entry;
    end
    if (in_acc) begin
      rd_entry_q <= mem_q[lever_id_i];
    end
  end

  // entry valid bits and last-write forwarding
  logic [lpdc_pkg::NumLevers-1:0] vld_q;
  logic                           fwd_vld_q;
  logic [lpdc_pkg::LeverW-1:0]    fwd_idx_q;
  lpdc_pkg::entry_t               fwd_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_vld_q <= 1'b0;
    end else if (wr_en) begin
      vld_q[s1_lever_q] <= 1'b1;
      fwd_vld_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_idx_q   <= s1_lever_q;
      fwd_entry_q <= upd_entry;
    end
  end

  // current entry: newest write, else memory, else reset value
  lpdc_pkg::entry_t cur_entry;

  always_comb begin
    if (fwd_vld_q && (fwd_idx_q == s1_lever_q)) begin
      cur_entry = fwd_entry_q;
    end else if (vld_q[s1_lever_q]) begin
      cur_entry = rd_entry_q;
    end else begin
      cur_entry = '0;
    end
  end

  assign in_range = int'(s1_lever_q) < lpdc_pkg::NumLevers;
  assign wr_en    = s1_vld_q && s1_adv && in_range;

  lpdc_update u_update (
    .cur_i         (cur_entry),
    .thr_i         (thr_q),
    .req_type_i    (s1_req_q),
    .lever_value_i (s1_value_q),
    .flag_mask_i   (s1_mask_q),
    .nxt_o         (upd_entry)
  );

  // output register
  logic [15:0] held_q;
  logic [1:0]  state_q;
  logic [15:0] ticks_q;
  logic [3:0]  bits_q;
  logic        all_set_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && s1_adv) begin
      if (in_range) begin
        held_q    <= upd_entry.kept;
        state_q   <= upd_entry.status;
        ticks_q   <= upd_entry.ticks;
        bits_q    <= upd_entry.flags;
        all_set_q <= (upd_entry.flags & s1_mask_q) == s1_mask_q;
      end else begin
        held_q    <= '0;
        state_q   <= '0;
        ticks_q   <= '0;
        bits_q    <= '0;
        all_set_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign held_value_o   = held_q;
  assign lever_state_o  = state_q;
  assign press_ticks_o  = ticks_q;
  assign event_bits_o   = bits_q;
  assign mask_all_set_o = all_set_q;

endmodule

// ===== rtl/lpdc_checker.sv =====
module lpdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] held_value_o,
  input logic [1:0]  lever_state_o,
  input logic [15:0] press_ticks_o,
  input logic [3:0]  event_bits_o,
  input logic        mask_all_set_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(held_value_o) && $stable(lever_state_o)
      && $stable(press_ticks_o) && $stable(event_bits_o) && $stable(mask_all_set_o))
    else $error("stalled result changed");

  // an empty output register never holds off a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with output register empty");

  // a pushed or timed-out lever has counted at least one tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lever_state_o == 2'(lpdc_pkg::ST_PUSHED)
      || lever_state_o == 2'(lpdc_pkg::ST_TIMEOUT)) |-> press_ticks_o != '0)
    else $error("active lever reports zero ticks");

endmodule

bind lever_press_duration_classifier lpdc_checker u_lpdc_checker (.*);

// ===== verif/tb_lever_press_duration_classifier.sv =====
`timescale 1ns / 1ps

module tb_lever_press_duration_classifier;
  import lpdc_pkg::*;

  localparam logic [3:0] EvAll = EvPressAll | EvPop;

  // one result as the block reports it
  typedef struct packed {
    logic [15:0] held;
    lever_st_e   state;
    logic [15:0] ticks;
    logic [3:0]  bits;
    logic        all_set;
  } press_report_t;

  // one row of the directed table
  typedef struct packed {
    req_e          req;
    logic [1:0]    id;
    logic [15:0]   val;
    logic [3:0]    mask;
    logic          typed;
    press_report_t want;
  } press_row_t;

  localparam press_report_t NoWant = '0;
  localparam int unsigned   PlanLen = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [1:0]  lever_id_i;
  logic [15:0] lever_value_i;
  logic [3:0]  flag_mask_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] held_value_o;
  logic [1:0]  lever_state_o;
  logic [15:0] press_ticks_o;
  logic [3:0]  event_bits_o;
  logic        mask_all_set_o;

  // predictor copy of thresholds and per-lever state
  thr_t          thr;
  entry_t        lever_mem [NumLevers];
  logic [15:0]   lever_aim [NumLevers];
  press_report_t pending_reports [$];
  press_report_t oldest;
  press_row_t    plan [PlanLen];
  int unsigned   mismatches = 0;
  int unsigned   calm_left  = 0;
  bit            brisk      = 1'b0;

  lever_press_duration_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .lever_id_i     (lever_id_i),
    .lever_value_i  (lever_value_i),
    .flag_mask_i    (flag_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .held_value_o   (held_value_o),
    .lever_state_o  (lever_state_o),
    .press_ticks_o  (press_ticks_o),
    .event_bits_o   (event_bits_o),
    .mask_all_set_o (mask_all_set_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // press classification of one request, updates the predictor state
  function automatic press_report_t classify_step(req_e req, logic [1:0] id,
                                                  logic [15:0] val, logic [3:0] mask);
    press_report_t rep;
    entry_t        e;
    logic [15:0]   c;
    rep = '0;
    if (id >= NumLevers) return rep;
    e = lever_mem[id];
    case (req)
      REQ_SCAN: begin
        // a changed reading restarts timing or ends the press
        if (e.last != val) begin
          e.last = val;
          e.kept = val;
          if (val != 16'd0) begin
            e.status = ST_PUSHED;
            e.ticks  = 16'd0;
            e.flags  = e.flags & ~EvPressAll;
          end else if (e.ticks >= thr.short_ticks) begin
            e.status = ST_POP;
            e.flags  = e.flags | EvPop;
          end else begin
            e.status = ST_IDLE;
          end
        end
        // count while pushed, long wins over mid wins over short
        if (e.status == ST_PUSHED) begin
          c = e.ticks;
          if (c != 16'hFFFF) c = c + 16'd1;
          e.ticks = c;
          if (c == thr.long_ticks) e.flags = e.flags | EvLong;
          else if (c == thr.mid_ticks) e.flags = e.flags | EvMid;
          else if (c == thr.short_ticks) e.flags = e.flags | EvShort;
          if (c > thr.long_ticks) e.status = ST_TIMEOUT;
        end
      end
      REQ_SET:   e.flags = e.flags | mask;
      REQ_CLEAR: e.flags = e.flags & ~mask;
      default: ;
    endcase
    lever_mem[id] = e;
    rep.held    = e.kept;
    rep.state   = e.status;
    rep.ticks   = e.ticks;
    rep.bits    = e.flags;
    rep.all_set = ((e.flags & mask) == mask);
    return rep;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < 20) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // sender gaps: mostly none or short, a few long, some calm stretches
  function automatic int unsigned next_gap();
    int unsigned r;
    if (brisk) return ($urandom_range(0, 99) < 2) ? 1 : 0;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // drive one request and record what it should produce
  task automatic issue_request(req_e req, logic [1:0] id, logic [15:0] val,
                               logic [3:0] mask, bit typed, press_report_t typed_want);
    int unsigned   gap;
    press_report_t got;
    gap = next_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    lever_id_i    <= id;
    lever_value_i <= val;
    flag_mask_i   <= mask;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = classify_step(req, id, val, mask);
    pending_reports.push_back(typed ? typed_want : got);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // threshold writes, only while the block is idle
  task automatic load_thresholds(logic [15:0] s, logic [15:0] m, logic [15:0] l);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgShort;
    cfg_data_i <= s;
    @(negedge clk_i);
    cfg_idx_i  <= CfgMid;
    cfg_data_i <= m;
    @(negedge clk_i);
    cfg_idx_i  <= CfgLong;
    cfg_data_i <= l;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    thr.short_ticks = s;
    thr.mid_ticks   = m;
    thr.long_ticks  = l;
  endtask

  // mostly held presses and releases, mixed with flag requests
  task automatic run_random_phase(int unsigned count, bit pause_mid);
    int unsigned r;
    int unsigned pick;
    logic [1:0]  id;
    logic [15:0] val;
    logic [3:0]  mask;
    req_e        req;
    for (int unsigned k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) drain_reports();
      r    = $urandom_range(0, 99);
      id   = 2'($urandom_range(0, 3));
      mask = 4'($urandom);
      val  = 16'($urandom);
      if (r < 70) begin
        req = REQ_SCAN;
        if ($urandom_range(0, 11) == 0) begin
          pick = $urandom_range(0, 9);
          lever_aim[id] = (pick < 4) ? 16'h0000 : (pick == 4) ? 16'hFFFF : 16'($urandom);
        end
        val = lever_aim[id];
      end else if (r < 78) begin
        req = REQ_SET;
      end else if (r < 86) begin
        req = REQ_CLEAR;
      end else begin
        req = REQ_TEST;
      end
      issue_request(req, id, val, mask, 1'b0, NoWant);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no request waiting");
      end else begin
        oldest = pending_reports.pop_front();
        if (held_value_o !== oldest.held)
          flag_mismatch($sformatf("held_value %h, want %h", held_value_o, oldest.held));
        if (lever_state_o !== oldest.state)
          flag_mismatch($sformatf("lever_state %0d, want %0d", lever_state_o, oldest.state));
        if (press_ticks_o !== oldest.ticks)
          flag_mismatch($sformatf("press_ticks %0d, want %0d", press_ticks_o, oldest.ticks));
        if (event_bits_o !== oldest.bits)
          flag_mismatch($sformatf("event_bits %h, want %h", event_bits_o, oldest.bits));
        if (mask_all_set_o !== oldest.all_set)
          flag_mismatch($sformatf("mask_all_set %b, want %b", mask_all_set_o,
                                  oldest.all_set));
      end
    end
  end

  // receiver stalls: short and long bursts, long open stretches
  initial begin
    int unsigned r;
    int unsigned len;
    bit          hold;
    out_stall_i = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (brisk) begin
        hold = (r < 3);
        len  = hold ? 1 : $urandom_range(20, 100);
      end else if (r < 50) begin
        hold = 1'b0;
        len  = $urandom_range(1, 8);
      end else if (r < 85) begin
        hold = 1'b1;
        len  = $urandom_range(1, 3);
      end else if (r < 95) begin
        hold = 1'b1;
        len  = $urandom_range(5, 30);
      end else begin
        hold = 1'b0;
        len  = $urandom_range(50, 200);
      end
      repeat (len) begin
        @(negedge clk_i);
        out_stall_i <= hold;
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    logic [15:0] s;
    logic [15:0] m;
    logic [15:0] l;
    int unsigned r;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgShort;
    cfg_data_i    = 16'd0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_SCAN;
    lever_id_i    = 2'd0;
    lever_value_i = 16'd0;
    flag_mask_i   = 4'h0;
    thr.short_ticks = ShortTicksRst;
    thr.mid_ticks   = MidTicksRst;
    thr.long_ticks  = LongTicksRst;
    for (int i = 0; i < NumLevers; i++) begin
      lever_mem[i] = '0;
      lever_aim[i] = 16'd0;
    end

    plan = '{
      '{REQ_TEST,  2'd0, 16'h0000, 4'h0, 1'b1, '{16'h0000, ST_IDLE, 16'd0, 4'h0, 1'b1}},
      '{REQ_TEST,  2'd3, 16'h0000, EvAll, 1'b1, '{16'h0000, ST_IDLE, 16'd0, 4'h0, 1'b0}},
      '{REQ_SET,   2'd1, 16'h0000, EvAll, 1'b1, '{16'h0000, ST_IDLE, 16'd0, EvAll, 1'b1}},
      '{REQ_CLEAR, 2'd1, 16'h0000, EvShort | EvLong, 1'b1,
        '{16'h0000, ST_IDLE, 16'd0, EvMid | EvPop, 1'b0}},
      '{REQ_TEST,  2'd1, 16'h0000, EvMid | EvPop, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'hFFFF, 4'h0, 1'b1, '{16'hFFFF, ST_PUSHED, 16'd1, 4'h0, 1'b1}},
      '{REQ_SCAN,  2'd0, 16'hFFFF, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'hFFFF, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'hFFFF, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'hFFFF, EvShort, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'hFFFF, EvShort, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'h0000, EvPop, 1'b0, NoWant},
      '{REQ_SCAN,  2'd0, 16'h0000, EvAll, 1'b0, NoWant},
      '{REQ_SCAN,  2'd1, 16'h0001, EvPop, 1'b0, NoWant},
      '{REQ_SCAN,  2'd1, 16'h0000, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd2, 16'h8000, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd2, 16'h7FFF, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd2, 16'h0000, 4'h0, 1'b0, NoWant},
      '{REQ_SET,   2'd3, 16'h0000, EvPop, 1'b0, NoWant},
      '{REQ_TEST,  2'd3, 16'h0000, EvPop, 1'b0, NoWant},
      '{REQ_CLEAR, 2'd3, 16'h0000, EvAll, 1'b0, NoWant},
      '{REQ_SCAN,  2'd3, 16'h5555, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd3, 16'hAAAA, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd3, 16'hAAAA, 4'h0, 1'b0, NoWant},
      '{REQ_SCAN,  2'd3, 16'hAAAA, EvShort, 1'b0, NoWant}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed requests under the reset thresholds
    for (int i = 0; i < PlanLen; i++)
      issue_request(plan[i].req, plan[i].id, plan[i].val, plan[i].mask,
                    plan[i].typed, plan[i].want);
    drain_reports();

    // lowest thresholds, all equal; lever 3 is already past the new long time
    load_thresholds(16'd1, 16'd1, 16'd1);
    issue_request(REQ_SCAN, 2'd3, 16'hAAAA, EvLong, 1'b0, NoWant);
    run_random_phase(40, 1'b0);
    drain_reports();

    // random thresholds, small so every flag and timeout is reached
    for (int p = 0; p < 8; p++) begin
      s = 16'($urandom_range(1, 8));
      m = s + 16'($urandom_range(0, 10));
      l = m + 16'($urandom_range(0, 15));
      r = $urandom_range(0, 9);
      if (r == 0) begin
        m = s;
        l = s;
      end else if (r == 1) begin
        l = m;
      end else if (r == 2) begin
        s = 16'($urandom_range(1, 30));
        m = 16'($urandom_range(1, 30));
        l = 16'($urandom_range(1, 30));
      end
      load_thresholds(s, m, l);
      run_random_phase(108, p == 3);
      drain_reports();
    end

    // highest thresholds: a held press back to back, then its release
    load_thresholds(16'hFFFE, 16'hFFFE, 16'hFFFE);
    brisk = 1'b1;
    for (int unsigned k = 0; k < 20; k++)
      issue_request(REQ_SCAN, 2'd2, 16'h1234, EvLong, 1'b0, NoWant);
    issue_request(REQ_SCAN, 2'd2, 16'h0000, EvPop, 1'b0, NoWant);
    brisk = 1'b0;
    drain_reports();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lpdc_pkg.sv
rtl/lpdc_update.sv
rtl/lever_press_duration_classifier.sv
rtl/lpdc_checker.sv
verif/tb_lever_press_duration_classifier.sv
